// ===== sv/bsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants of the bank switch mapper with scanline IRQ.
// ----------------------------------------------------------------------------
package bsm_pkg;

	localparam int unsigned AddrW    = 16;
	localparam int unsigned DataW    = 8;
	localparam int unsigned RomAddrW = 21;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 9;
	localparam int unsigned BankCntW = 9;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_PRG   = 2'd1,
		OP_CHR   = 2'd2,
		OP_A12   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RGN_PRG_ROM  = 2'd0,
		RGN_PRG_RAM  = 2'd1,
		RGN_CHR_ROM  = 2'd2,
		RGN_UNMAPPED = 2'd3
	} region_t;

	typedef enum logic [1:0] {
		MIR_VERTICAL   = 2'd0,
		MIR_HORIZONTAL = 2'd1,
		MIR_FOUR       = 2'd2
	} mirror_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_PRG_BANK_COUNT     = 3'd0,
		CFG_HAS_IRQ            = 3'd1,
		CFG_HAS_MIRROR_CONTROL = 3'd2,
		CFG_FOUR_SCREEN        = 3'd3,
		CFG_INITIAL_MIRROR     = 3'd4
	} cfg_idx_t;

	localparam logic [AddrW-1:0] RegDecodeMask = 16'hE001;
	localparam logic [AddrW-1:0] RegBankSel    = 16'h8000;
	localparam logic [AddrW-1:0] RegBankData   = 16'h8001;
	localparam logic [AddrW-1:0] RegMirror     = 16'hA000;
	localparam logic [AddrW-1:0] RegIrqLatch   = 16'hC000;
	localparam logic [AddrW-1:0] RegIrqReload  = 16'hC001;
	localparam logic [AddrW-1:0] RegIrqDisable = 16'hE000;
	localparam logic [AddrW-1:0] RegIrqEnable  = 16'hE001;

	localparam logic [AddrW-1:0] PrgRamBase = 16'h6000;
	localparam logic [AddrW-1:0] PrgRomBase = 16'h8000;
	localparam logic [AddrW-1:0] ChrLimit   = 16'h2000;

	localparam int unsigned BankSelPrgBit = 6;
	localparam int unsigned BankSelChrBit = 7;

	typedef struct packed {
		logic [BankCntW-1:0] prg_bank_count;
		logic                has_irq;
		logic                has_mirror_control;
		logic                four_screen;
	} cfg_t;

	typedef struct packed {
		logic [2:0]            bank_index;
		logic                  prg_swap;
		logic                  chr_swap;
		logic [7:0][DataW-1:0] bank_regs;
	} map_state_t;

endpackage

// ===== sv/bsm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_req_if / bsm_rsp_if
// Valid/ready channels that carry mapper operations and their results.
// ----------------------------------------------------------------------------
interface bsm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] addr;
	logic [7:0]  data;

	modport source (output valid, output op, output addr, output data, input ready);
	modport sink (input valid, input op, input addr, input data, output ready);
endinterface

interface bsm_rsp_if;
	logic        valid;
	logic        ready;
	logic [20:0] rom_address;
	logic [1:0]  region;
	logic        irq_line;
	logic [1:0]  mirror_mode;

	modport source (output valid, output rom_address, output region, output irq_line,
		output mirror_mode, input ready);
	modport sink (input valid, input rom_address, input region, input irq_line,
		input mirror_mode, output ready);
endinterface

// ===== sv/bsm_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_regs
// Configuration registers, CPU register decode, bank registers and the
// scanline IRQ counter. Gives the IRQ line and mirroring after the current word is applied.
// ----------------------------------------------------------------------------
module bsm_regs
	import bsm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                upd,
	input  op_t                 op,
	input  logic [AddrW-1:0]    addr,
	input  logic [DataW-1:0]    data,
	output cfg_t                cfg,
	output map_state_t          st,
	output logic                irq_next,
	output logic                mirror_next
);

	cfg_t             cfg_q;
	map_state_t       st_q;
	map_state_t       st_d;
	logic [DataW-1:0] latch_q, latch_d;
	logic [DataW-1:0] count_q, count_d;
	logic             reload_q, reload_d;
	logic             enabled_q, enabled_d;
	logic             pending_q, pending_d;
	logic             mirror_q, mirror_d;

	always_comb begin
		st_d      = st_q;
		latch_d   = latch_q;
		count_d   = count_q;
		reload_d  = reload_q;
		enabled_d = enabled_q;
		pending_d = pending_q;
		mirror_d  = mirror_q;
		if (op == OP_WRITE) begin
			case (addr & RegDecodeMask)
				RegBankSel: begin
					st_d.bank_index = data[2:0];
					st_d.prg_swap   = data[BankSelPrgBit];
					st_d.chr_swap   = data[BankSelChrBit];
				end
				RegBankData: st_d.bank_regs[st_q.bank_index] = data;
				RegMirror: begin
					if (cfg_q.has_mirror_control && !cfg_q.four_screen) begin
						mirror_d = data[0];
					end
				end
				RegIrqLatch: latch_d = data;
				RegIrqReload: begin
					if (cfg_q.has_irq) begin
						count_d  = '0;
						reload_d = 1'b1;
					end
				end
				RegIrqDisable: begin
					if (cfg_q.has_irq) begin
						enabled_d = 1'b0;
						pending_d = 1'b0;
					end
				end
				RegIrqEnable: begin
					if (cfg_q.has_irq) begin
						enabled_d = 1'b1;
					end
				end
				default: ;
			endcase
		end else if (op == OP_A12 && cfg_q.has_irq) begin
			if (count_q == '0 || reload_q) begin
				count_d = latch_q;
			end else begin
				count_d = count_q - DataW'(1);
			end
			if (count_d == '0 && enabled_q) begin
				pending_d = 1'b1;
			end
			reload_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prg_bank_count     <= BankCntW'(32);
			cfg_q.has_irq            <= 1'b1;
			cfg_q.has_mirror_control <= 1'b1;
			cfg_q.four_screen        <= 1'b0;
			st_q      <= '0;
			latch_q   <= '0;
			count_q   <= '0;
			reload_q  <= 1'b0;
			enabled_q <= 1'b0;
			pending_q <= 1'b0;
			mirror_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PRG_BANK_COUNT:     cfg_q.prg_bank_count <= cfg_data;
					CFG_HAS_IRQ:            cfg_q.has_irq <= cfg_data[0];
					CFG_HAS_MIRROR_CONTROL: cfg_q.has_mirror_control <= cfg_data[0];
					CFG_FOUR_SCREEN:        cfg_q.four_screen <= cfg_data[0];
					CFG_INITIAL_MIRROR:     mirror_q <= cfg_data[0];
					default: ;
				endcase
			end else if (upd) begin
				st_q      <= st_d;
				latch_q   <= latch_d;
				count_q   <= count_d;
				reload_q  <= reload_d;
				enabled_q <= enabled_d;
				pending_q <= pending_d;
				mirror_q  <= mirror_d;
			end
		end
	end

	assign cfg         = cfg_q;
	assign st          = st_q;
	assign irq_next    = pending_d;
	assign mirror_next = mirror_d;

endmodule

// ===== sv/bsm_xlate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_xlate
// Translates a PRG or CHR bus address into a ROM byte address and region.
// ----------------------------------------------------------------------------
module bsm_xlate
	import bsm_pkg::*;
(
	input  op_t                 op,
	input  logic [AddrW-1:0]    addr,
	input  cfg_t                cfg,
	input  map_state_t          st,
	output logic [RomAddrW-1:0] rom_address,
	output region_t             region
);

	logic [BankCntW-1:0] last_bank;
	logic [BankCntW-1:0] second_bank;
	logic [BankCntW-1:0] prg_bank;
	logic [AddrW-1:0]    chr_a;
	logic [DataW-1:0]    chr_bank;
	logic [2:0]          chr_sel;

	assign last_bank   = cfg.prg_bank_count - BankCntW'(1);
	assign second_bank = cfg.prg_bank_count - BankCntW'(2);
	assign chr_a       = st.chr_swap ? (addr ^ 16'h1000) : addr;
	assign chr_sel     = 3'd2 + {1'b0, chr_a[11:10]};

	always_comb begin
		case (addr[14:13])
			2'd0:    prg_bank = st.prg_swap ? second_bank : {1'b0, st.bank_regs[6]};
			2'd1:    prg_bank = {1'b0, st.bank_regs[7]};
			2'd2:    prg_bank = st.prg_swap ? {1'b0, st.bank_regs[6]} : second_bank;
			default: prg_bank = last_bank;
		endcase
	end

	always_comb begin
		rom_address = '0;
		region      = RGN_UNMAPPED;
		chr_bank    = '0;
		case (op)
			OP_PRG: begin
				if (addr >= PrgRomBase) begin
					region      = RGN_PRG_ROM;
					rom_address = {prg_bank[7:0], addr[12:0]};
				end else if (addr >= PrgRamBase) begin
					region      = RGN_PRG_RAM;
					rom_address = RomAddrW'(addr[12:0]);
				end
			end
			OP_CHR: begin
				if (addr < ChrLimit) begin
					region = RGN_CHR_ROM;
					if (!chr_a[12]) begin
						chr_bank    = st.bank_regs[{2'b00, chr_a[11]}];
						rom_address = RomAddrW'({chr_bank[7:1], chr_a[10:0]});
					end else begin
						chr_bank    = st.bank_regs[chr_sel];
						rom_address = RomAddrW'({chr_bank, chr_a[9:0]});
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/bank_switch_mapper_scanline_irq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_switch_mapper_scanline_irq
// Bank-switching cartridge mapper with PRG/CHR translation and scanline IRQ.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word is held in the input register; when it
// advances, its result is loaded into the result register that drives rsp.
// Throughput: one word per cycle unless rsp stalls; the input register and
// the result register let a new word enter while a result waits on rsp.
// Reset: arst_n clears the pipeline and all mapper state at once and loads
// the default configuration.
module bank_switch_mapper_scanline_irq
	import bsm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	bsm_req_if.sink             req,
	bsm_rsp_if.source           rsp,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic                valid_s1;
	op_t                 op_s1;
	logic [AddrW-1:0]    addr_s1;
	logic [DataW-1:0]    data_s1;
	logic                advance;

	logic                out_valid_q;
	logic [RomAddrW-1:0] rom_address_q;
	region_t             region_q;
	logic                irq_q;
	mirror_t             mirror_q;

	cfg_t                cfg;
	map_state_t          st;
	logic                irq_next;
	logic                mirror_next;
	logic [RomAddrW-1:0] rom_address;
	region_t             region;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1   <= op_t'(req.op);
			addr_s1 <= req.addr;
			data_s1 <= req.data;
		end
	end

	bsm_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.upd         (advance),
		.op          (op_s1),
		.addr        (addr_s1),
		.data        (data_s1),
		.cfg         (cfg),
		.st          (st),
		.irq_next    (irq_next),
		.mirror_next (mirror_next)
	);

	bsm_xlate u_xlate (
		.op          (op_s1),
		.addr        (addr_s1),
		.cfg         (cfg),
		.st          (st),
		.rom_address (rom_address),
		.region      (region)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rom_address_q <= rom_address;
			region_q      <= region;
			irq_q         <= irq_next;
			mirror_q      <= cfg.four_screen ? MIR_FOUR : mirror_t'({1'b0, mirror_next});
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.rom_address = rom_address_q;
	assign rsp.region      = region_q;
	assign rsp.irq_line    = irq_q;
	assign rsp.mirror_mode = mirror_q;

endmodule

// ===== dv/bsm_mapper_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_mapper_checker
// Watches the operation and result channels and the register port of the
// mapper. It keeps its own copy of the mapper state, predicts the result word
// of every accepted operation, and compares each result word, field by field,
// with the oldest prediction.
// ----------------------------------------------------------------------------
module bsm_mapper_checker
	import bsm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	bsm_req_if                  req,
	bsm_rsp_if                  rsp,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output int unsigned         mismatches,
	output int unsigned         words_in_flight
);

	localparam int unsigned PrintCap = 40;

	typedef struct packed {
		logic [RomAddrW-1:0] rom_address;
		region_t             region;
		logic                irq_line;
		mirror_t             mirror_mode;
	} map_word_t;

	logic [BankCntW-1:0] bank_count;
	logic                irq_present;
	logic                mirror_ctl;
	logic                four_scr;
	logic [2:0]          sel_index;
	logic                prg_swap;
	logic                chr_swap;
	logic [DataW-1:0]    bank_reg [8];
	logic [7:0]          latch_val;
	logic [7:0]          counter;
	logic                reload_req;
	logic                irq_en;
	logic                irq_pend;
	logic                mirror_h;
	map_word_t           expected_words [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < PrintCap)
			$display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic map_word_t predict_mapper_word(input op_t op, input logic [AddrW-1:0] a,
		input logic [DataW-1:0] d);
		map_word_t             w;
		logic [BankCntW-1:0]   last_bank;
		logic [BankCntW-1:0]   second_bank;
		logic [BankCntW-1:0]   bank;
		logic [BankCntW+12:0]  wide;
		logic [12:0]           ca;
		logic [DataW-1:0]      cbank;
		w.rom_address = '0;
		w.region = RGN_UNMAPPED;
		last_bank = bank_count - 1'b1;
		second_bank = bank_count - 2'd2;
		case (op)
			OP_WRITE: begin
				case (a & RegDecodeMask)
					RegBankSel: begin
						sel_index = d[2:0];
						prg_swap = d[BankSelPrgBit];
						chr_swap = d[BankSelChrBit];
					end
					RegBankData: bank_reg[sel_index] = d;
					RegMirror: begin
						if (mirror_ctl && !four_scr)
							mirror_h = d[0];
					end
					RegIrqLatch: latch_val = d;
					RegIrqReload: begin
						if (irq_present) begin
							counter = '0;
							reload_req = 1'b1;
						end
					end
					RegIrqDisable: begin
						if (irq_present) begin
							irq_en = 1'b0;
							irq_pend = 1'b0;
						end
					end
					RegIrqEnable: begin
						if (irq_present)
							irq_en = 1'b1;
					end
					default: ;
				endcase
			end
			OP_PRG: begin
				if (a >= PrgRamBase && a < PrgRomBase) begin
					w.region = RGN_PRG_RAM;
					w.rom_address = RomAddrW'(a[12:0]);
				end else if (a >= PrgRomBase) begin
					w.region = RGN_PRG_ROM;
					case (a[14:13])
						2'd0: bank = prg_swap ? second_bank : BankCntW'(bank_reg[6]);
						2'd1: bank = BankCntW'(bank_reg[7]);
						2'd2: bank = prg_swap ? BankCntW'(bank_reg[6]) : second_bank;
						default: bank = last_bank;
					endcase
					wide = {bank, a[12:0]};
					w.rom_address = wide[RomAddrW-1:0];
				end
			end
			OP_CHR: begin
				if (a < ChrLimit) begin
					w.region = RGN_CHR_ROM;
					ca = chr_swap ? (a[12:0] ^ 13'h1000) : a[12:0];
					if (!ca[12]) begin
						cbank = bank_reg[{2'b00, ca[11]}] & 8'hFE;
						w.rom_address = RomAddrW'({cbank, 10'b0}) + RomAddrW'(ca[10:0]);
					end else begin
						cbank = bank_reg[3'd2 + {1'b0, ca[11:10]}];
						w.rom_address = RomAddrW'({cbank, ca[9:0]});
					end
				end
			end
			default: begin
				if (irq_present) begin
					if (counter == 8'd0 || reload_req)
						counter = latch_val;
					else
						counter = counter - 8'd1;
					if (counter == 8'd0 && irq_en)
						irq_pend = 1'b1;
					reload_req = 1'b0;
				end
			end
		endcase
		w.irq_line = irq_pend;
		w.mirror_mode = four_scr ? MIR_FOUR : (mirror_h ? MIR_HORIZONTAL : MIR_VERTICAL);
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		map_word_t want;
		if (!arst_n) begin
			bank_count = BankCntW'(32);
			irq_present = 1'b1;
			mirror_ctl = 1'b1;
			four_scr = 1'b0;
			sel_index = '0;
			prg_swap = 1'b0;
			chr_swap = 1'b0;
			foreach (bank_reg[i])
				bank_reg[i] = '0;
			latch_val = '0;
			counter = '0;
			reload_req = 1'b0;
			irq_en = 1'b0;
			irq_pend = 1'b0;
			mirror_h = 1'b0;
			expected_words.delete();
			words_in_flight <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected result word", 32'(rsp.rom_address), '0);
				end else begin
					want = expected_words.pop_front();
					if (rsp.rom_address !== want.rom_address)
						report_mismatch("rom_address", 32'(rsp.rom_address),
							32'(want.rom_address));
					if (rsp.region !== want.region)
						report_mismatch("region", 32'(rsp.region), 32'(want.region));
					if (rsp.irq_line !== want.irq_line)
						report_mismatch("irq_line", 32'(rsp.irq_line), 32'(want.irq_line));
					if (rsp.mirror_mode !== want.mirror_mode)
						report_mismatch("mirror_mode", 32'(rsp.mirror_mode),
							32'(want.mirror_mode));
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PRG_BANK_COUNT: bank_count = cfg_data;
					CFG_HAS_IRQ: irq_present = cfg_data[0];
					CFG_HAS_MIRROR_CONTROL: mirror_ctl = cfg_data[0];
					CFG_FOUR_SCREEN: four_scr = cfg_data[0];
					CFG_INITIAL_MIRROR: mirror_h = cfg_data[0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				expected_words.push_back(predict_mapper_word(op_t'(req.op), req.addr, req.data));
			words_in_flight <= expected_words.size();
		end
	end

endmodule

// ===== dv/tb_bank_switch_mapper_scanline_irq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bank_switch_mapper_scanline_irq
// Drives the mapper with a short directed sequence and then with phases of
// random register writes, PRG and CHR lookups and A12 rises, each phase under
// its own register setting, with random gaps and stalls on both channels in most phases.
// ----------------------------------------------------------------------------
module tb_bank_switch_mapper_scanline_irq;
	import bsm_pkg::*;

	localparam int unsigned WordsPerPhase = 155;
	localparam int unsigned PhaseCount    = 10;
	localparam int unsigned CycleLimit    = 200000;
	localparam int unsigned SettleCycles  = 4;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	int unsigned         mismatches;
	int unsigned         words_in_flight;
	int unsigned         idle_pct;
	int unsigned         stall_left;

	bsm_req_if req_ch ();
	bsm_rsp_if rsp_ch ();

	bank_switch_mapper_scanline_irq dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bsm_mapper_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.words_in_flight (words_in_flight)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n) begin
			stall_left <= 0;
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			stall_left <= $urandom_range(0, 3);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	task automatic pause_sender(input int unsigned n);
		req_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_word(input op_t op, input logic [AddrW-1:0] a,
		input logic [DataW-1:0] d);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
			pause_sender($urandom_range(1, 4));
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.addr <= a;
		req_ch.data <= d;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic load_config(input logic [CfgDataW-1:0] banks, input logic irq_on,
		input logic mirror_on, input logic four_on, input logic mirror_init);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PRG_BANK_COUNT;
		cfg_data <= banks;
		@(posedge clk);
		cfg_index <= CFG_HAS_IRQ;
		cfg_data <= CfgDataW'(irq_on);
		@(posedge clk);
		cfg_index <= CFG_HAS_MIRROR_CONTROL;
		cfg_data <= CfgDataW'(mirror_on);
		@(posedge clk);
		cfg_index <= CFG_FOUR_SCREEN;
		cfg_data <= CfgDataW'(four_on);
		@(posedge clk);
		cfg_index <= CFG_INITIAL_MIRROR;
		cfg_data <= CfgDataW'(mirror_init);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random_word();
		logic [AddrW-1:0] a;
		logic [AddrW-1:0] reg_base;
		logic [DataW-1:0] d;
		int unsigned      pick;
		a = AddrW'($urandom);
		d = DataW'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 32) begin
			case ($urandom_range(0, 9))
				0: reg_base = RegBankSel;
				1, 2: reg_base = RegBankData;
				3: reg_base = RegMirror;
				4: reg_base = RegIrqLatch;
				5: reg_base = RegIrqReload;
				6: reg_base = RegIrqDisable;
				default: reg_base = RegIrqEnable;
			endcase
			// Short latch values let the counter reach zero often.
			if (reg_base == RegIrqLatch && $urandom_range(0, 1) == 1)
				d = DataW'($urandom_range(0, 6));
			send_word(OP_WRITE, {reg_base[15:13], a[12:1], reg_base[0]}, d);
		end else if (pick < 37) begin
			send_word(OP_WRITE, a, d);
		end else if (pick < 62) begin
			send_word(OP_PRG, a, d);
		end else if (pick < 82) begin
			send_word(OP_CHR, ($urandom_range(0, 9) == 0) ? a : (a & (ChrLimit - 1'b1)), d);
		end else begin
			send_word(OP_A12, a, d);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_WRITE;
		req_ch.addr <= '0;
		req_ch.data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_PRG_BANK_COUNT;
		cfg_data <= '0;
		idle_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_PRG, 16'h0000, 8'h00);
		send_word(OP_PRG, 16'h6000, 8'hFF);
		send_word(OP_PRG, 16'h7FFF, 8'h00);
		send_word(OP_PRG, 16'hFFFF, 8'hFF);
		send_word(OP_WRITE, RegBankSel, 8'h06);
		send_word(OP_WRITE, RegBankData, 8'hFF);
		send_word(OP_WRITE, RegBankSel, 8'h07);
		send_word(OP_WRITE, RegBankData, 8'h81);
		send_word(OP_PRG, 16'h8000, 8'h00);
		send_word(OP_PRG, 16'hBFFF, 8'h00);
		send_word(OP_PRG, 16'hC000, 8'h00);
		send_word(OP_WRITE, RegBankSel, 8'hC0);
		send_word(OP_WRITE, RegBankData, 8'hFF);
		send_word(OP_PRG, 16'h9FFF, 8'h00);
		send_word(OP_PRG, 16'hDFFF, 8'h00);
		send_word(OP_CHR, 16'h0000, 8'h00);
		send_word(OP_CHR, 16'h1FFF, 8'h00);
		send_word(OP_CHR, 16'h2000, 8'h00);
		send_word(OP_WRITE, RegMirror, 8'h01);
		send_word(OP_WRITE, {RegMirror[15:1], 1'b1}, 8'h00);
		send_word(OP_WRITE, 16'h7FFF, 8'hFF);
		send_word(OP_WRITE, RegIrqLatch, 8'h00);
		send_word(OP_WRITE, RegIrqEnable, 8'h00);
		send_word(OP_A12, 16'h1000, 8'h00);
		send_word(OP_WRITE, RegIrqDisable, 8'h00);
		wait_for_results();

		for (int phase = 0; phase < PhaseCount; phase++) begin
			case (phase)
				0: load_config(CfgDataW'(2), 1'b1, 1'b1, 1'b0, 1'b1);
				1: load_config(CfgDataW'(256), 1'b0, 1'b1, 1'b0, 1'b0);
				2: load_config(CfgDataW'(256), 1'b1, 1'b0, 1'b0, 1'b1);
				3: load_config(CfgDataW'(2), 1'b1, 1'b1, 1'b1, 1'b0);
				default: load_config(CfgDataW'($urandom_range(2, 256)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) == 0),
					1'($urandom_range(0, 1)));
			endcase
			if (phase == 2 || phase == PhaseCount - 1)
				idle_pct = 0;
			else
				idle_pct = 10 + 15 * (phase % 3);
			repeat (WordsPerPhase) send_random_word();
			wait_for_results();
		end

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/bsm_pkg.sv
sv/bsm_if.sv
sv/bsm_regs.sv
sv/bsm_xlate.sv
sv/bank_switch_mapper_scanline_irq.sv
dv/bsm_mapper_checker.sv
dv/tb_bank_switch_mapper_scanline_irq.sv
